/* rtl/bsag_pkg.sv */
// ============================================================================
// bsag_pkg: shared types and constants of the slot allocator
// Request and result payloads, controller commands and status, request
// codes and the lowest-free-bit encoder.
// ============================================================================
package bsag_pkg;

  localparam int NUM_WORDS_DEF = 64;
  localparam int MAP_WIDTH     = 64;
  localparam int BIT_BITS      = 6;

  localparam logic [6:0]  ACTIVE_WORDS_RESET = 7'd64;
  localparam logic [63:0] MAP_ONE            = 64'd1;
  localparam logic [63:0] MAP_FULL           = '1;

  localparam logic [1:0] KIND_ALLOC    = 2'd0;
  localparam logic [1:0] KIND_FREE     = 2'd1;
  localparam logic [1:0] KIND_VALIDATE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] slot_index;
    logic [31:0] handle_generation;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] granted_slot;
    logic [31:0] granted_generation;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic scan_init;
    logic scan;
    logic claim;
    logic gen_update;
    logic free_wr;
    logic val_chk;
    logic res_fail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] kind;
    logic       in_range;
    logic       scan_found;
    logic       scan_fail;
    logic       out_free;
  } status_t;

  // Index of the lowest clear bit; the caller guarantees one exists.
  function automatic logic [BIT_BITS-1:0] lowest_zero(input logic [MAP_WIDTH-1:0] word);
    logic [MAP_WIDTH-1:0] inv;
    logic [MAP_WIDTH-1:0] first;
    logic [BIT_BITS-1:0]  idx;
    inv   = ~word;
    first = inv & (~inv + MAP_ONE);
    idx   = '0;
    for (int i = 0; i < MAP_WIDTH; i++) begin
      if (first[i]) begin
        idx = idx | BIT_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/bsag_ram.sv */
// ============================================================================
// bsag_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module bsag_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bsag_ctrl.sv */
// ============================================================================
// bsag_ctrl: request sequencer of the slot allocator
// Steps through the clearing pass, request decode, bitmap scan, claim,
// free, validate and result hand-off, commanding the datapath.
// ============================================================================
module bsag_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsag_pkg::status_t st,
  output bsag_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CLAIM,
    S_GEN_UPD,
    S_FREE_WR,
    S_VAL_CHK,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.kind)
          bsag_pkg::KIND_ALLOC: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          bsag_pkg::KIND_FREE: begin
            if (st.in_range) begin
              state_next = S_FREE_WR;
            end else begin
              cmd.res_fail = 1'b1;
              state_next   = S_RESULT;
            end
          end
          bsag_pkg::KIND_VALIDATE: begin
            if (st.in_range) begin
              state_next = S_VAL_CHK;
            end else begin
              cmd.res_fail = 1'b1;
              state_next   = S_RESULT;
            end
          end
          default: begin
            cmd.res_fail = 1'b1;
            state_next   = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_found) begin
          state_next = S_CLAIM;
        end else if (st.scan_fail) begin
          cmd.res_fail = 1'b1;
          state_next   = S_RESULT;
        end
      end
      S_CLAIM: begin
        cmd.claim  = 1'b1;
        state_next = S_GEN_UPD;
      end
      S_GEN_UPD: begin
        cmd.gen_update = 1'b1;
        state_next     = S_RESULT;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_next  = S_RESULT;
      end
      S_VAL_CHK: begin
        cmd.val_chk = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_stall <= 1'b1;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

/* rtl/bsag_dp.sv */
// ============================================================================
// bsag_dp: datapath of the slot allocator
// Holds the bitmap and generation memories, the configuration register,
// the scan pointers, the request and result registers and the output stage.
// ============================================================================
module bsag_dp #(
  parameter int NUM_WORDS = bsag_pkg::NUM_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bsag_pkg::cmd_t      cmd,
  output bsag_pkg::status_t   st,
  input  bsag_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  input  logic [6:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bsag_pkg::out_item_t out_item
);

  localparam int WW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int AW    = WW + bsag_pkg::BIT_BITS;
  localparam int DEPTH = NUM_WORDS * bsag_pkg::MAP_WIDTH;
  localparam int CMPW  = (WW + 1 > 7) ? WW + 1 : 7;

  logic [6:0]          active_words;
  logic [6:0]          words;
  logic [WW-1:0]       resume;
  logic [WW-1:0]       scan_addr;
  logic [6:0]          scan_left;
  logic                chk_valid;
  logic [WW-1:0]       chk_word;
  logic [WW-1:0]       found_word;
  logic [5:0]          found_bit;
  logic [63:0]         found_data;
  logic [AW-1:0]       clr_addr;
  bsag_pkg::in_item_t  req;
  bsag_pkg::out_item_t res;

  logic [WW:0]         scan_inc;
  logic                resume_ok;
  logic [WW-1:0]       req_word;
  logic [AW-1:0]       req_slot;
  logic [AW-1:0]       found_slot;
  logic [63:0]         req_mask;

  logic                bm_we;
  logic [WW-1:0]       bm_waddr;
  logic [63:0]         bm_wdata;
  logic [WW-1:0]       bm_raddr;
  logic [63:0]         bm_rdata;
  logic                gen_we;
  logic [AW-1:0]       gen_waddr;
  logic [31:0]         gen_wdata;
  logic [AW-1:0]       gen_raddr;
  logic [31:0]         gen_rdata;
  logic [31:0]         gen_new;

  assign words      = (int'(active_words) < NUM_WORDS) ? active_words : 7'(NUM_WORDS);
  assign scan_inc   = {1'b0, scan_addr} + (WW + 1)'(1);
  assign resume_ok  = CMPW'(resume) < CMPW'(words);
  assign req_word   = WW'(req.slot_index[11:6]);
  assign req_slot   = AW'(req.slot_index);
  assign found_slot = {found_word, found_bit};
  assign req_mask   = bsag_pkg::MAP_ONE << req.slot_index[5:0];
  assign gen_new    = (gen_rdata == 32'hFFFF_FFFF) ? 32'd1 : gen_rdata + 32'd1;

  assign st.clear_done = (clr_addr == AW'(DEPTH - 1));
  assign st.kind       = req.kind;
  assign st.in_range   = {1'b0, req.slot_index[11:6]} < words;
  assign st.scan_found = chk_valid && (bm_rdata != bsag_pkg::MAP_FULL);
  assign st.scan_fail  = !chk_valid && (scan_left == 7'd0);
  assign st.out_free   = !out_valid || !out_stall;

  assign bm_we     = cmd.clear || cmd.free_wr || cmd.claim;
  assign bm_waddr  = cmd.clear ? clr_addr[AW-1:bsag_pkg::BIT_BITS]
                   : (cmd.free_wr ? req_word : found_word);
  assign bm_wdata  = cmd.clear ? '0
                   : (cmd.free_wr ? (bm_rdata & ~req_mask)
                                  : (found_data | (bsag_pkg::MAP_ONE << found_bit)));
  assign bm_raddr  = cmd.scan ? scan_addr : req_word;

  assign gen_we    = cmd.clear || cmd.gen_update;
  assign gen_waddr = cmd.clear ? clr_addr : found_slot;
  assign gen_wdata = cmd.clear ? '0 : gen_new;
  assign gen_raddr = cmd.claim ? found_slot : req_slot;

  bsag_ram #(
    .WIDTH (bsag_pkg::MAP_WIDTH),
    .DEPTH (NUM_WORDS),
    .AW    (WW)
  ) u_map_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  bsag_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_words <= bsag_pkg::ACTIVE_WORDS_RESET;
      resume       <= '0;
      scan_addr    <= '0;
      scan_left    <= '0;
      chk_valid    <= 1'b0;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_words <= cfg_data;
      end
      if (cmd.clear && !st.clear_done) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.scan_init) begin
        scan_addr <= resume_ok ? resume : '0;
        scan_left <= words;
        chk_valid <= 1'b0;
      end else if (cmd.scan) begin
        if (scan_left != 7'd0) begin
          chk_valid <= 1'b1;
          scan_left <= scan_left - 7'd1;
          if (CMPW'(scan_inc) == CMPW'(words)) begin
            scan_addr <= '0;
          end else begin
            scan_addr <= scan_inc[WW-1:0];
          end
        end else begin
          chk_valid <= 1'b0;
        end
      end
      if (cmd.claim) begin
        resume <= found_word;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_item;
    end
    if (cmd.scan) begin
      chk_word <= scan_addr;
      if (st.scan_found) begin
        found_word <= chk_word;
        found_bit  <= bsag_pkg::lowest_zero(bm_rdata);
        found_data <= bm_rdata;
      end
    end
    if (cmd.res_fail) begin
      res <= '0;
    end else if (cmd.free_wr) begin
      res <= '{ok: 1'b1, granted_slot: 12'd0, granted_generation: 32'd0};
    end else if (cmd.val_chk) begin
      res.ok                 <= (req.handle_generation != 32'd0)
                                && (gen_rdata == req.handle_generation);
      res.granted_slot       <= 12'd0;
      res.granted_generation <= 32'd0;
    end else if (cmd.gen_update) begin
      res.ok                 <= 1'b1;
      res.granted_slot       <= 12'(found_slot);
      res.granted_generation <= gen_new;
    end
    if (cmd.out_load) begin
      out_item <= res;
    end
  end

endmodule

/* rtl/bitmap_slot_allocator_generations_core.sv */
// ============================================================================
// bitmap_slot_allocator_generations_core: next-fit slot allocator
// Allocates, frees and validates slots over a bitmap of 64-bit words, with a
// 32-bit generation per slot that is bumped on every allocation.
//
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   in_item  (kind, slot_index, handle_generation)
//   out       out_valid / out_stall out_item (ok, granted_slot, granted_generation)
//   cfg       cfg_valid / cfg_ready cfg_data (active_words)
//
// Allocate passes through decode, bitmap scan, claim and generation update;
// the bitmap memory delivers one word a cycle. Free and validate pass through
// decode and a write or check state; an unknown or out-of-range request goes
// from decode straight to the result. After reset a clearing pass zeroes both
// memories while in_stall stays high; configuration writes are taken
// throughout. A finished result waits in the output register while the next
// request is accepted and processed; the register is reloaded once free.
// ============================================================================
module bitmap_slot_allocator_generations_core #(
  parameter int NUM_WORDS = bsag_pkg::NUM_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsag_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bsag_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  bsag_pkg::cmd_t    cmd;
  bsag_pkg::status_t st;

  assign cfg_ready = 1'b1;

  bsag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bsag_dp #(
    .NUM_WORDS (NUM_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_item   (in_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Request transfer did not make the block busy.");

  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("Requests were accepted before the clearing pass.");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |=> !out_valid)
    else $error("A result appeared in the cycle after a request transfer.");

endmodule

/* verif/bitmap_slot_allocator_generations_core_tb.sv */
// ============================================================================
// bitmap_slot_allocator_generations_core_tb: slot allocator testbench
// Sends allocate, free, validate and unknown-kind requests on the valid/stall
// request channel and checks each result against a directed row's expected
// value or an in-bench next-fit allocator with per-slot generations. A short
// table of directed requests and register writes comes first. Random phases
// follow, each with its own word count. Both channels idle at random.
// ============================================================================
module bitmap_slot_allocator_generations_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         NUM_PHASES  = 10;
  localparam int         DIR_COUNT   = 24;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    bit                  cfg_row;
    logic [6:0]          cfg_val;
    bsag_pkg::in_item_t  req;
    bit                  typed;
    bsag_pkg::out_item_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{1'b0, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b1, '{1'b1, 12'd0, 32'd1}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b1, '{1'b1, 12'd1, 32'd1}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd0, 32'd1},
      1'b1, '{1'b1, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd0, 32'd0},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd0, 32'hFFFF_FFFF},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_FREE, 12'd0, 32'd0},
      1'b1, '{1'b1, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_FREE, 12'd0, 32'd0},
      1'b1, '{1'b1, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd0, 32'd1},
      1'b1, '{1'b1, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b1, '{1'b1, 12'd0, 32'd2}},
    '{1'b0, 7'd0, '{KIND_UNUSED, 12'd4095, 32'hFFFF_FFFF},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_FREE, 12'd4095, 32'd0},
      1'b1, '{1'b1, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd4095, 32'd0},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b1, 7'd1, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b0, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd1, 32'd1},
      1'b1, '{1'b1, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_FREE, 12'd64, 32'd0},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd4095, 32'd1},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b1, '{1'b1, 12'd2, 32'd1}},
    '{1'b1, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b0, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd4095, 32'hFFFF_FFFF},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_FREE, 12'd0, 32'd0},
      1'b1, '{1'b0, 12'd0, 32'd0}},
    '{1'b1, 7'd127, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b0, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_ALLOC, 12'd0, 32'd0},
      1'b0, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_FREE, 12'd63, 32'd0},
      1'b0, '{1'b0, 12'd0, 32'd0}},
    '{1'b0, 7'd0, '{bsag_pkg::KIND_VALIDATE, 12'd2, 32'd1},
      1'b0, '{1'b0, 12'd0, 32'd0}}
  };

  localparam logic [6:0] PHASE_WORDS [NUM_PHASES] = '{
    7'd3, 7'd1, 7'd2, 7'd0, 7'd64, 7'd1, 7'd127, 7'd4, 7'd1, 7'd2
  };
  localparam int PHASE_ALLOC_PCT [NUM_PHASES] = '{70, 70, 70, 50, 40, 35, 50, 70, 70, 35};

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bsag_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bsag_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [6:0]          cfg_data  = '0;

  logic [63:0] map_words [64];
  logic [31:0] gen_store [4096];
  logic [5:0]  next_word;
  logic [6:0]  words_cfg;

  bsag_pkg::out_item_t result_q [$];
  logic [11:0]         live_q [$];
  bsag_pkg::out_item_t oldest;

  int unsigned errors     = 0;
  int unsigned n_requests = 0;
  int unsigned n_settings = 0;
  int unsigned n_grant    = 0;
  int unsigned n_exhaust  = 0;
  int unsigned n_match    = 0;
  int unsigned n_freed    = 0;
  int unsigned burst_left = 0;
  int unsigned rx_hold    = 0;
  int unsigned rx_run     = 0;

  bitmap_slot_allocator_generations_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit claim_word(input int w, output logic [11:0] slot);
    slot = '0;
    if (map_words[w] == bsag_pkg::MAP_FULL) return 1'b0;
    for (int b = 0; b < 64; b++) begin
      if (!map_words[w][b]) begin
        map_words[w][b] = 1'b1;
        next_word = w[5:0];
        slot = {w[5:0], b[5:0]};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bsag_pkg::out_item_t allocator_result(input bsag_pkg::in_item_t req);
    bsag_pkg::out_item_t res;
    int                  in_use;
    int                  start;
    bit                  hit;
    logic [11:0]         slot;
    logic [31:0]         gen;
    res = '0;
    hit = 1'b0;
    in_use = (words_cfg < 7'd64) ? int'(words_cfg) : 64;
    case (req.kind)
      bsag_pkg::KIND_ALLOC: begin
        start = int'(next_word);
        for (int w = start; w < in_use && !hit; w++) hit = claim_word(w, slot);
        for (int w = 0; w < start && w < in_use && !hit; w++) hit = claim_word(w, slot);
        if (hit) begin
          gen = gen_store[slot] + 32'd1;
          if (gen == 32'd0) gen = 32'd1;
          gen_store[slot] = gen;
          res = '{1'b1, slot, gen};
        end
      end
      bsag_pkg::KIND_FREE: begin
        if (int'(req.slot_index[11:6]) < in_use) begin
          map_words[req.slot_index[11:6]][req.slot_index[5:0]] = 1'b0;
          res.ok = 1'b1;
        end
      end
      bsag_pkg::KIND_VALIDATE: begin
        res.ok = (int'(req.slot_index[11:6]) < in_use) && (req.handle_generation != 32'd0)
                 && (gen_store[req.slot_index] == req.handle_generation);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic bsag_pkg::in_item_t random_request(input int alloc_pct);
    bsag_pkg::in_item_t r;
    int                 pick;
    int                 i;
    r.kind = KIND_UNUSED;
    r.slot_index = 12'($urandom);
    r.handle_generation = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      r.kind = bsag_pkg::KIND_ALLOC;
    end else if (pick < alloc_pct + 20) begin
      r.kind = bsag_pkg::KIND_FREE;
      if (live_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        i = $urandom_range(0, live_q.size() - 1);
        r.slot_index = live_q[i];
        live_q.delete(i);
      end
    end else if (pick < 96) begin
      r.kind = bsag_pkg::KIND_VALIDATE;
      if (live_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        i = $urandom_range(0, live_q.size() - 1);
        r.slot_index = live_q[i];
        case ($urandom_range(0, 3))
          0: r.handle_generation = gen_store[r.slot_index] + 32'd1;
          1: r.handle_generation = gen_store[r.slot_index] - 32'd1;
          default: r.handle_generation = gen_store[r.slot_index];
        endcase
      end else if ($urandom_range(0, 3) == 0) begin
        r.handle_generation = '0;
      end
    end
    return r;
  endfunction

  function automatic void report_failure(input string what, input bsag_pkg::out_item_t want,
                                         input bsag_pkg::out_item_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t %s: expected ok=%0b slot=%0d gen=%0h, got ok=%0b slot=%0d gen=%0h",
               $realtime, what, want.ok, want.granted_slot, want.granted_generation,
               got.ok, got.granted_slot, got.granted_generation);
    end
  endfunction

  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_request(input bsag_pkg::in_item_t req, input bit typed,
                              input bsag_pkg::out_item_t want);
    bsag_pkg::out_item_t pred;
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = allocator_result(req);
    result_q.push_back(typed ? want : pred);
    n_requests++;
    if (req.kind == bsag_pkg::KIND_ALLOC) begin
      if (pred.ok) begin
        n_grant++;
        live_q.push_back(pred.granted_slot);
      end else begin
        n_exhaust++;
      end
    end
    if (req.kind == bsag_pkg::KIND_VALIDATE && pred.ok) n_match++;
    if (req.kind == bsag_pkg::KIND_FREE && pred.ok) n_freed++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_words(input logic [6:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    words_cfg = value;
    n_settings++;
  endtask

  // The receiver stalls for a short stretch, then takes results for a run of
  // random length; long runs leave stretches with no stall at all.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (rx_run != 0) begin
      out_stall <= 1'b0;
      rx_run <= rx_run - 1;
    end else begin
      out_stall <= 1'b0;
      rx_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      rx_hold <= $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_failure("result transfer with nothing outstanding", '0, out_item);
      end else begin
        oldest = result_q.pop_front();
        if (out_item.ok !== oldest.ok || out_item.granted_slot !== oldest.granted_slot
            || out_item.granted_generation !== oldest.granted_generation) begin
          report_failure("result mismatch", oldest, out_item);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", result_q.size());
    $display("** bitmap_slot_allocator_generations_core: FAILED **");
    $finish;
  end

  initial begin
    for (int w = 0; w < 64; w++) map_words[w] = '0;
    for (int s = 0; s < 4096; s++) gen_store[s] = '0;
    next_word = '0;
    words_cfg = bsag_pkg::ACTIVE_WORDS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_COUNT; r++) begin
      if (DIR_ROWS[r].cfg_row) begin
        drain_results();
        write_words(DIR_ROWS[r].cfg_val);
      end else begin
        pace_sender();
        send_request(DIR_ROWS[r].req, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_words(PHASE_WORDS[p]);
      for (int k = 0; k < ((PHASE_WORDS[p] == 7'd0) ? 40 : 200); k++) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        pace_sender();
        send_request(random_request(PHASE_ALLOC_PCT[p]), 1'b0, '0);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (result_q.size() != 0) begin
      errors += result_q.size();
      $display("%0d expected results never arrived.", result_q.size());
    end
    $display("Ran %0d requests under %0d word-count settings, %0d mismatches.",
             n_requests, n_settings, errors);
    $display("Slots granted %0d, allocates refused %0d, frees done %0d, handles matched %0d.",
             n_grant, n_exhaust, n_freed, n_match);
    if (errors == 0) begin
      $display("** bitmap_slot_allocator_generations_core: PASSED **");
    end else begin
      $display("** bitmap_slot_allocator_generations_core: FAILED **");
    end
    $finish;
  end

endmodule
